// ===== design/mft_pkg.sv =====
// ----------------------------------------------------------------------------
// mft_pkg
// shared types and constants of the motor feedback multi-turn tracker
// ----------------------------------------------------------------------------
package mft_pkg;

  localparam int BUSES_DEF     = 4;
  localparam int SLOTS_DEF     = 8;
  localparam int REG_BITS      = 32;

  localparam logic [10:0] ID_FIRST    = 11'h201;
  localparam logic [10:0] ID_LAST     = 11'h208;
  localparam logic [3:0]  GOOD_LENGTH = 4'd8;
  localparam int          HALF_TURN   = 4096;
  localparam int          TURN_SHIFT  = 13;

  typedef enum logic [2:0] {
    ST_TRACKED  = 3'd0,
    ST_ZERO_SET = 3'd1,
    ST_ZERO_CLR = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_BAD_ID   = 3'd4,
    ST_NOT_REG  = 3'd5
  } status_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic track;
  } stat_t;

endpackage

// ===== design/mft_ctrl.sv =====
// ----------------------------------------------------------------------------
// mft_ctrl
// sequencer: capture, turn update, write back and result
// ----------------------------------------------------------------------------
module mft_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mft_pkg::stat_t stat,
  output mft_pkg::cmd_t  cmd,
  output logic          busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = stat.track ? S_CALC : S_DONE;
        end
      end
      S_CALC: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.calc    = (state_r == S_CALC);
  assign cmd.finish  = (state_r == S_DONE);
  assign busy        = busy_r;

endmodule

// ===== design/mft_datapath.sv =====
// ----------------------------------------------------------------------------
// mft_datapath
// frame checks, field decode, per-slot state memories and position unwrap
// ----------------------------------------------------------------------------
module mft_datapath #(
  parameter int BUSES         = mft_pkg::BUSES_DEF,
  parameter int SLOTS_PER_BUS = mft_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mft_pkg::cmd_t       cmd,
  output mft_pkg::stat_t      stat,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic                in_opcode,
  input  logic [1:0]          in_bus_index,
  input  logic [10:0]         in_frame_id,
  input  logic [3:0]          in_frame_length,
  input  logic [63:0]         in_payload,
  input  logic [2:0]          in_zero_slot,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [1:0]          out_bus_out,
  output logic [2:0]          out_motor_slot,
  output logic [15:0]         out_encoder_angle,
  output logic signed [15:0]  out_speed_rpm,
  output logic signed [15:0]  out_current_raw,
  output logic [7:0]          out_temperature,
  output logic signed [31:0]  out_absolute_position
);

  localparam int NSLOT = BUSES * SLOTS_PER_BUS;
  localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  // configuration
  logic [31:0] reg_slots_r;

  // request classification
  logic [10:0]      id_off;
  logic             id_in_range;
  logic             id_ok;
  logic             bus_ok;
  logic             zs_ok;
  logic [2:0]       slot_id;
  logic [2:0]       slot_sel;
  logic [31:0]      idx_full;
  logic             reg_ok;
  mft_pkg::status_t code;
  logic [2:0]       slot_out;

  // captured request
  mft_pkg::status_t code_r;
  logic [1:0]       bus_r;
  logic [2:0]       slot_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      ang_r;
  logic [15:0]      spd_r;
  logic [15:0]      cur_r;
  logic [7:0]       tmp_r;

  // per-slot state
  logic [NSLOT-1:0] cal_r;
  logic [15:0]      zero_mem [NSLOT];
  logic [15:0]      last_mem [NSLOT];
  logic [31:0]      turn_mem [NSLOT];
  logic [15:0]      zero_q;
  logic [15:0]      last_q;
  logic [31:0]      turn_q;

  // unwrap
  logic             cal_hit_r;
  logic [31:0]      turn_r;
  logic signed [16:0] diff;
  logic [31:0]      turn_nxt;
  logic [31:0]      pos;
  logic             trk;

  // output registers
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [1:0]       out_bus_r;
  logic [2:0]       out_slot_r;
  logic [15:0]      out_ang_r;
  logic [15:0]      out_spd_r;
  logic [15:0]      out_cur_r;
  logic [7:0]       out_tmp_r;
  logic [31:0]      out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_slots_r <= '0;
    end else if (cfg_we) begin
      reg_slots_r <= cfg_data;
    end
  end

  always_comb begin
    id_off      = in_frame_id - mft_pkg::ID_FIRST;
    id_in_range = (in_frame_id >= mft_pkg::ID_FIRST) && (in_frame_id <= mft_pkg::ID_LAST);
    id_ok       = id_in_range && (32'(id_off) < 32'(SLOTS_PER_BUS));
    bus_ok      = 32'(in_bus_index) < 32'(BUSES);
    zs_ok       = 32'(in_zero_slot) < 32'(SLOTS_PER_BUS);
    slot_id     = id_off[2:0];
    slot_sel    = in_opcode ? in_zero_slot : slot_id;
    idx_full    = 32'(in_bus_index) * 32'(SLOTS_PER_BUS) + 32'(slot_sel);
    reg_ok      = (idx_full < 32'(mft_pkg::REG_BITS)) && reg_slots_r[idx_full[4:0]];

    priority if (in_opcode) begin
      code     = (bus_ok && zs_ok) ? mft_pkg::ST_ZERO_CLR : mft_pkg::ST_NOT_REG;
      slot_out = in_zero_slot;
    end else if (!bus_ok) begin
      code     = mft_pkg::ST_NOT_REG;
      slot_out = id_in_range ? slot_id : 3'd0;
    end else if (!id_ok) begin
      code     = mft_pkg::ST_BAD_ID;
      slot_out = 3'd0;
    end else if (!reg_ok) begin
      code     = mft_pkg::ST_NOT_REG;
      slot_out = slot_id;
    end else if (in_frame_length != mft_pkg::GOOD_LENGTH) begin
      code     = mft_pkg::ST_BAD_LEN;
      slot_out = slot_id;
    end else begin
      code     = mft_pkg::ST_TRACKED;
      slot_out = slot_id;
    end
  end

  assign stat.track = (code == mft_pkg::ST_TRACKED);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r <= code;
      bus_r  <= in_bus_index;
      slot_r <= slot_out;
      idx_r  <= idx_full[IDX_W-1:0];
      ang_r  <= in_payload[63:48];
      spd_r  <= in_payload[47:32];
      cur_r  <= in_payload[31:16];
      tmp_r  <= in_payload[15:8];
    end
  end

  // slot state memories, read at capture, written back at finish
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      zero_q <= zero_mem[idx_full[IDX_W-1:0]];
      last_q <= last_mem[idx_full[IDX_W-1:0]];
      turn_q <= turn_mem[idx_full[IDX_W-1:0]];
    end
    if (cmd.finish && trk) begin
      last_mem[idx_r] <= ang_r;
      turn_mem[idx_r] <= turn_r;
      if (!cal_hit_r) begin
        zero_mem[idx_r] <= ang_r;
      end
    end
  end

  assign trk = (code_r == mft_pkg::ST_TRACKED);

  // turn counting
  always_comb begin
    diff = $signed({1'b0, last_q}) - $signed({1'b0, ang_r});
    if (diff > 17'sd4096) begin
      turn_nxt = turn_q + 32'd1;
    end else if (diff < -17'sd4096) begin
      turn_nxt = turn_q - 32'd1;
    end else begin
      turn_nxt = turn_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      cal_hit_r <= cal_r[idx_r];
      turn_r    <= cal_r[idx_r] ? turn_nxt : 32'd0;
    end
  end

  assign pos = (turn_r << mft_pkg::TURN_SHIFT) + {16'd0, ang_r} - {16'd0, zero_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cmd.finish) begin
      if (trk) begin
        cal_r[idx_r] <= 1'b1;
      end else if (code_r == mft_pkg::ST_ZERO_CLR) begin
        cal_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_bus_r  <= bus_r;
      out_slot_r <= slot_r;
      if (trk) begin
        out_status_r <= cal_hit_r ? mft_pkg::ST_TRACKED : mft_pkg::ST_ZERO_SET;
        out_ang_r    <= ang_r;
        out_spd_r    <= spd_r;
        out_cur_r    <= cur_r;
        out_tmp_r    <= tmp_r;
        out_pos_r    <= cal_hit_r ? pos : 32'd0;
      end else begin
        out_status_r <= code_r;
        out_ang_r    <= '0;
        out_spd_r    <= '0;
        out_cur_r    <= '0;
        out_tmp_r    <= '0;
        out_pos_r    <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_bus_out           = out_bus_r;
  assign out_motor_slot        = out_slot_r;
  assign out_encoder_angle     = out_ang_r;
  assign out_speed_rpm         = $signed(out_spd_r);
  assign out_current_raw       = $signed(out_cur_r);
  assign out_temperature       = out_tmp_r;
  assign out_absolute_position = $signed(out_pos_r);

endmodule

// ===== design/motor_feedback_multiturn_tracker_top.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_top
// checks motor feedback frames and unwraps the encoder angle per slot
// ----------------------------------------------------------------------------
// command channel: an item transfers at a clock edge with start high and busy
//   low; in_opcode selects a feedback frame or a zero clear of one slot
// result channel: out_valid marks each result for exactly one cycle; the
//   receiver takes it at the end of that cycle and cannot hold it off
// config channel: cfg_registered_slots transfers on cfg_valid and cfg_ready,
//   ready is always high; write it only while busy is low
// latency: out_valid rises 2 cycles after the transfer edge for a tracked
//   frame (state read and turn update, then write back), 1 for any other item
// throughput: one item every 3 cycles for tracked frames, 2 for the rest,
//   set by the read, update and write back of the per-slot state memories
// busy is high while an item is in work; out_valid comes with busy low so a
//   new item may transfer in the same cycle a result is shown
// reset: synchronous on rst_n, clears the registered slot mask and every
//   calibrated flag; no result is pending afterwards
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_top #(
  parameter int BUSES         = mft_pkg::BUSES_DEF,
  parameter int SLOTS_PER_BUS = mft_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_opcode,
  input  logic [1:0]          in_bus_index,
  input  logic [10:0]         in_frame_id,
  input  logic [3:0]          in_frame_length,
  input  logic [63:0]         in_payload,
  input  logic [2:0]          in_zero_slot,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [1:0]          out_bus_out,
  output logic [2:0]          out_motor_slot,
  output logic [15:0]         out_encoder_angle,
  output logic signed [15:0]  out_speed_rpm,
  output logic signed [15:0]  out_current_raw,
  output logic [7:0]          out_temperature,
  output logic signed [31:0]  out_absolute_position,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_registered_slots
);

  mft_pkg::cmd_t  cmd;
  mft_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  mft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mft_datapath #(
    .BUSES         (BUSES),
    .SLOTS_PER_BUS (SLOTS_PER_BUS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_data              (cfg_registered_slots),
    .in_opcode             (in_opcode),
    .in_bus_index          (in_bus_index),
    .in_frame_id           (in_frame_id),
    .in_frame_length       (in_frame_length),
    .in_payload            (in_payload),
    .in_zero_slot          (in_zero_slot),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_bus_out           (out_bus_out),
    .out_motor_slot        (out_motor_slot),
    .out_encoder_angle     (out_encoder_angle),
    .out_speed_rpm         (out_speed_rpm),
    .out_current_raw       (out_current_raw),
    .out_temperature       (out_temperature),
    .out_absolute_position (out_absolute_position)
  );

endmodule

// ===== design/mft_checker.sv =====
// ----------------------------------------------------------------------------
// mft_checker
// port-level checks of the tracker, bound to the top level
// ----------------------------------------------------------------------------
module mft_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         start,
  input logic         busy,
  input logic         out_valid,
  input logic [2:0]   out_status,
  input logic [15:0]  out_encoder_angle,
  input logic [31:0]  out_absolute_position
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  a_result_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result shown outside the end of an item");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mft_pkg::ST_TRACKED && out_status != mft_pkg::ST_ZERO_SET
    |-> out_encoder_angle == 16'd0 && out_absolute_position == 32'd0)
    else $error("fields not cleared for a rejected item");

  a_zero_set_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mft_pkg::ST_ZERO_SET |-> out_absolute_position == 32'd0)
    else $error("nonzero position on zero record");

endmodule

bind motor_feedback_multiturn_tracker_top mft_checker u_mft_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .out_valid             (out_valid),
  .out_status            (out_status),
  .out_encoder_angle     (out_encoder_angle),
  .out_absolute_position (out_absolute_position)
);
